[sv/linear_probe_hash_table_core_macros.svh]
// Assertion macros for the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LPHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lpht_pkg.sv]
// Types, codes and the key hash for the linear probing hash table.
package lpht_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_EXISTING  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  localparam int SLOT_OUT_W  = 10;
  localparam int COUNT_W     = 16;
  localparam int TOTAL_W     = 11;
  localparam int KEY_BYTES   = 12;
  localparam int HASH_ROT    = 3;
  localparam int MOD_BITS    = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic               valid;
    logic [63:0]        key_low;
    logic [31:0]        key_high;
    logic [COUNT_W-1:0] count;
  } slot_word_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_PROBE,
    BK_CLEAR,
    BK_FIN
  } back_state_t;

  // Each byte ends up rotated left by three bits for itself and for every byte that follows it,
  // the last byte included, so the hash is an XOR of fixed rotations.
  function automatic logic [63:0] key_hash(input logic [63:0] lo, input logic [31:0] hi);
    logic [95:0] key;
    logic [63:0] acc;
    logic [63:0] byte_ext;
    int          sh;
    key = {hi, lo};
    acc = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      byte_ext = {56'd0, key[8*b +: 8]};
      sh = (HASH_ROT * (KEY_BYTES - b)) % 64;
      acc = acc ^ ((byte_ext << sh) | (byte_ext >> (64 - sh)));
    end
    return acc;
  endfunction

endpackage

[sv/linear_probe_hash_table_core.sv]
// Insert or lookup: slots are probed from the home slot until the key or an empty slot is found or all were probed.
// When TABLE_DEPTH is not a power of two the home slot is reduced from the hash by modulo, 8 modulo bits per cycle.
// Clear: every slot is written, one slot written per cycle through the RAM write port.
// Throughput is one operation at a time in the probe engine; the front end hashes the next meanwhile.
// After rst the slot RAM is swept with in_stall high; the table starts empty.
module linear_probe_hash_table_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      kind,
  input  logic [63:0]                     key_low,
  input  logic [31:0]                     key_high,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [lpht_pkg::SLOT_OUT_W-1:0] slot_index,
  output logic [lpht_pkg::COUNT_W-1:0]    value_count,
  output logic [lpht_pkg::TOTAL_W-1:0]    entry_total
);

  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int QW = 2 + 64 + 32 + SLOT_W;

  logic              init_busy;
  logic              q_full;
  logic              q_push;
  logic [1:0]        f_kind;
  logic [63:0]       f_key_low;
  logic [31:0]       f_key_high;
  logic [SLOT_W-1:0] f_home;
  logic              q_valid;
  logic              q_pop;
  logic [QW-1:0]     q_dout;

  lpht_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .key_low    (key_low),
    .key_high   (key_high),
    .init_busy  (init_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_kind     (f_kind),
    .q_key_low  (f_key_low),
    .q_key_high (f_key_high),
    .q_home     (f_home)
  );

  lpht_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({f_kind, f_key_low, f_key_high, f_home}),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_dout),
    .pop   (q_pop)
  );

  lpht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_kind      (q_dout[QW-1 -: 2]),
    .q_key_low   (q_dout[QW-3 -: 64]),
    .q_key_high  (q_dout[SLOT_W+31 -: 32]),
    .q_home      (q_dout[SLOT_W-1:0]),
    .q_pop       (q_pop),
    .init_busy   (init_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot_index  (slot_index),
    .value_count (value_count),
    .entry_total (entry_total)
  );

endmodule

[sv/lpht_ram.sv]
// Generic simple dual-port RAM with registered read.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/lpht_queue.sv]
// Two-entry queue between the hashing front end and the probe engine.
module lpht_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] dout,
  input  logic             pop
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign dout  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

[sv/lpht_front.sv]
// Front end: accepts beats, drops unused kinds and reduces the key hash to a home slot.
module lpht_front #(
  parameter int TABLE_DEPTH = 1024,
  localparam int SLOT_W = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [63:0]       key_low,
  input  logic [31:0]       key_high,
  input  logic              init_busy,
  input  logic              q_full,
  output logic              q_push,
  output logic [1:0]        q_kind,
  output logic [63:0]       q_key_low,
  output logic [31:0]       q_key_high,
  output logic [SLOT_W-1:0] q_home
);

  localparam bit POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
  localparam int RW = SLOT_W + 1;
  localparam logic [RW-1:0] DEPTH_R = RW'(TABLE_DEPTH);

  logic          f_valid;
  logic          done;
  logic [2:0]    step;
  logic [1:0]    f_kind;
  logic [63:0]   f_key_low;
  logic [31:0]   f_key_high;
  logic [63:0]   hsh;
  logic [RW-1:0] rem;
  logic [RW-1:0] rem_next;
  logic          accept;

  assign q_push   = f_valid && done && !q_full;
  assign in_stall = init_busy || (f_valid && !q_push);
  assign accept   = in_valid && !in_stall;

  // Eight restoring modulo steps per cycle, most significant hash bit first.
  always_comb begin
    logic [RW-1:0] r;
    r = rem;
    for (int i = 0; i < lpht_pkg::MOD_BITS; i++) begin
      r = {r[SLOT_W-1:0], hsh[63-i]};
      if (r >= DEPTH_R) begin
        r = r - DEPTH_R;
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      done    <= 1'b0;
      step    <= 3'd0;
    end else begin
      if (q_push) begin
        f_valid <= 1'b0;
      end
      if (accept && kind != lpht_pkg::KIND_NONE) begin
        f_valid <= 1'b1;
        done    <= POW2;
        step    <= 3'd0;
      end else if (f_valid && !done) begin
        step <= step + 3'd1;
        if (step == 3'd7) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_kind     <= kind;
      f_key_low  <= key_low;
      f_key_high <= key_high;
      hsh        <= lpht_pkg::key_hash(key_low, key_high);
      rem        <= '0;
    end else if (f_valid && !done) begin
      hsh <= hsh << lpht_pkg::MOD_BITS;
      rem <= rem_next;
    end
  end

  assign q_kind     = f_kind;
  assign q_key_low  = f_key_low;
  assign q_key_high = f_key_high;
  assign q_home     = POW2 ? hsh[SLOT_W-1:0] : rem[SLOT_W-1:0];

endmodule

[sv/lpht_back.sv]
// Probe engine: walks the slot RAM, applies inserts and clears, and holds the result beat.
`include "linear_probe_hash_table_core_macros.svh"

module lpht_back #(
  parameter int TABLE_DEPTH = 1024,
  localparam int SLOT_W = $clog2(TABLE_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  logic [1:0]                        q_kind,
  input  logic [63:0]                       q_key_low,
  input  logic [31:0]                       q_key_high,
  input  logic [SLOT_W-1:0]                 q_home,
  output logic                              q_pop,
  output logic                              init_busy,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic [lpht_pkg::SLOT_OUT_W-1:0]   slot_index,
  output logic [lpht_pkg::COUNT_W-1:0]      value_count,
  output logic [lpht_pkg::TOTAL_W-1:0]      entry_total
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int WW = $bits(lpht_pkg::slot_word_t);
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TABLE_DEPTH - 1);

  lpht_pkg::back_state_t state, state_next;

  logic [SLOT_W-1:0]            idx;
  logic [SLOT_W-1:0]            idx_inc;
  logic [SLOT_W-1:0]            probe_n;
  logic [1:0]                   op_kind;
  logic [63:0]                  op_key_low;
  logic [31:0]                  op_key_high;
  logic [CNT_W-1:0]             entries;
  logic [2:0]                   res_status;
  logic [SLOT_W-1:0]            res_slot;
  logic [lpht_pkg::COUNT_W-1:0] res_count;
  logic                         wr_pend;
  lpht_pkg::slot_word_t         wr_word;

  logic                         ram_we;
  logic [SLOT_W-1:0]            ram_waddr;
  logic [WW-1:0]                ram_wdata;
  logic [SLOT_W-1:0]            ram_raddr;
  logic [WW-1:0]                ram_rdata;
  lpht_pkg::slot_word_t         rd_word;

  logic                         out_free;
  logic                         out_load;
  logic                         is_empty;
  logic                         is_match;
  logic                         resolved;
  logic [lpht_pkg::COUNT_W-1:0] cnt_inc;

  lpht_ram #(.WIDTH(WW), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (1'b1),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_word  = lpht_pkg::slot_word_t'(ram_rdata);
  assign idx_inc  = (idx == LAST) ? '0 : idx + 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign is_empty = !rd_word.valid;
  assign is_match = rd_word.valid && rd_word.key_low == op_key_low &&
                    rd_word.key_high == op_key_high;
  assign resolved = is_empty || is_match || (probe_n == LAST);
  assign cnt_inc  = (rd_word.count == lpht_pkg::COUNT_MAX) ? rd_word.count
                                                            : rd_word.count + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      lpht_pkg::BK_INIT: begin
        if (idx == LAST) begin
          state_next = lpht_pkg::BK_IDLE;
        end
      end
      lpht_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_next = (q_kind == lpht_pkg::KIND_CLEAR) ? lpht_pkg::BK_CLEAR
                                                        : lpht_pkg::BK_PROBE;
        end
      end
      lpht_pkg::BK_PROBE: begin
        if (resolved) begin
          state_next = lpht_pkg::BK_FIN;
        end
      end
      lpht_pkg::BK_CLEAR: begin
        if (idx == LAST) begin
          state_next = lpht_pkg::BK_FIN;
        end
      end
      lpht_pkg::BK_FIN: begin
        if (out_free) begin
          state_next = lpht_pkg::BK_IDLE;
        end
      end
      default: state_next = lpht_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    init_busy = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    ram_raddr = idx_inc;
    unique case (state)
      lpht_pkg::BK_INIT: begin
        init_busy = 1'b1;
        ram_we    = 1'b1;
      end
      lpht_pkg::BK_IDLE: begin
        q_pop     = q_valid;
        ram_raddr = q_home;
      end
      lpht_pkg::BK_PROBE: begin
        ram_raddr = idx_inc;
      end
      lpht_pkg::BK_CLEAR: begin
        ram_we = 1'b1;
      end
      lpht_pkg::BK_FIN: begin
        out_load  = out_free;
        ram_we    = out_free && wr_pend;
        ram_wdata = wr_word;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpht_pkg::BK_INIT;
      idx       <= '0;
      entries   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        lpht_pkg::BK_INIT: begin
          idx <= idx_inc;
        end
        lpht_pkg::BK_IDLE: begin
          if (q_valid) begin
            idx <= (q_kind == lpht_pkg::KIND_CLEAR) ? '0 : q_home;
          end
        end
        lpht_pkg::BK_PROBE: begin
          if (is_empty && op_kind == lpht_pkg::KIND_INSERT) begin
            entries <= entries + 1'b1;
          end else if (!resolved) begin
            idx <= idx_inc;
          end
        end
        lpht_pkg::BK_CLEAR: begin
          idx <= idx_inc;
          if (idx == LAST) begin
            entries <= '0;
          end
        end
        lpht_pkg::BK_FIN: begin
          idx <= idx;
        end
        default: begin
          idx <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == lpht_pkg::BK_IDLE && q_valid) begin
      op_kind     <= q_kind;
      op_key_low  <= q_key_low;
      op_key_high <= q_key_high;
      probe_n     <= '0;
    end
    if (state == lpht_pkg::BK_CLEAR) begin
      res_status <= lpht_pkg::ST_CLEARED;
      res_slot   <= '0;
      res_count  <= '0;
      wr_pend    <= 1'b0;
    end
    if (state == lpht_pkg::BK_PROBE) begin
      if (is_empty) begin
        if (op_kind == lpht_pkg::KIND_INSERT) begin
          wr_pend    <= 1'b1;
          wr_word    <= '{valid: 1'b1, key_low: op_key_low, key_high: op_key_high,
                          count: lpht_pkg::COUNT_W'(1)};
          res_status <= lpht_pkg::ST_NEW;
          res_slot   <= idx;
          res_count  <= lpht_pkg::COUNT_W'(1);
        end else begin
          wr_pend    <= 1'b0;
          res_status <= lpht_pkg::ST_NOT_FOUND;
          res_slot   <= '0;
          res_count  <= '0;
        end
      end else if (is_match) begin
        res_slot <= idx;
        if (op_kind == lpht_pkg::KIND_INSERT) begin
          wr_pend    <= 1'b1;
          wr_word    <= '{valid: 1'b1, key_low: op_key_low, key_high: op_key_high,
                          count: cnt_inc};
          res_status <= lpht_pkg::ST_EXISTING;
          res_count  <= cnt_inc;
        end else begin
          wr_pend    <= 1'b0;
          res_status <= lpht_pkg::ST_FOUND;
          res_count  <= rd_word.count;
        end
      end else if (probe_n == LAST) begin
        wr_pend    <= 1'b0;
        res_status <= (op_kind == lpht_pkg::KIND_INSERT) ? lpht_pkg::ST_FULL
                                                         : lpht_pkg::ST_NOT_FOUND;
        res_slot   <= '0;
        res_count  <= '0;
      end else begin
        probe_n <= probe_n + 1'b1;
      end
    end
    if (out_load) begin
      status      <= res_status;
      slot_index  <= lpht_pkg::SLOT_OUT_W'(res_slot);
      value_count <= res_count;
      entry_total <= lpht_pkg::TOTAL_W'(entries);
    end
  end

  `LPHT_ASSERT_NOW(a_entries_bound, clk, rst, 1'b1, entries <= CNT_W'(TABLE_DEPTH), "table holds more keys than slots")
  `LPHT_ASSERT_NOW(a_cleared_zero, clk, rst, out_valid && status == lpht_pkg::ST_CLEARED, slot_index == '0 && value_count == '0 && entry_total == '0, "clear result carries nonzero fields")
  `LPHT_ASSERT_NOW(a_new_count_one, clk, rst, out_valid && status == lpht_pkg::ST_NEW, value_count == lpht_pkg::COUNT_W'(1) && entry_total != '0, "new key result is inconsistent")
  `LPHT_ASSERT_NEXT(a_pop_leaves_idle, clk, rst, q_pop, state == lpht_pkg::BK_PROBE || state == lpht_pkg::BK_CLEAR, "queue pop did not start an operation")

endmodule
